[rtl/core/lvsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lvsp_pkg
// Shared types, phase codes, status codes and character constants of the
// label/value spec parser.
// ----------------------------------------------------------------------------
package lvsp_pkg;

   // sizes
   localparam int MAX_TEXT_LEN = 4096;
   localparam int MAX_PAIRS    = 256;
   localparam logic [15:0] VISIT_BUDGET_RESET = 16'd10000;

   // parse phases
   localparam logic [3:0] PH_START = 4'd0;
   localparam logic [3:0] PH_LABEL = 4'd1;
   localparam logic [3:0] PH_OPENQ = 4'd2;
   localparam logic [3:0] PH_OQ2   = 4'd3;
   localparam logic [3:0] PH_OQ7   = 4'd4;
   localparam logic [3:0] PH_VALUE = 4'd5;
   localparam logic [3:0] PH_VQ2   = 4'd6;
   localparam logic [3:0] PH_VQ7   = 4'd7;
   localparam logic [3:0] PH_COMMA = 4'd8;

   // status codes
   localparam logic [1:0] ST_RUN     = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_UNEXP   = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   // error sites
   localparam logic [3:0] SITE_NONE      = 4'd0;
   localparam logic [3:0] SITE_START     = 4'd1;
   localparam logic [3:0] SITE_LABEL     = 4'd2;
   localparam logic [3:0] SITE_OQ_SEVEN  = 4'd3;
   localparam logic [3:0] SITE_OQ_TWO    = 4'd4;
   localparam logic [3:0] SITE_OQ_OTHER  = 4'd5;
   localparam logic [3:0] SITE_VAL_SEVEN = 4'd6;
   localparam logic [3:0] SITE_VAL_TWO   = 4'd7;
   localparam logic [3:0] SITE_VAL_OTHER = 4'd8;
   localparam logic [3:0] SITE_COMMA     = 4'd9;

   // field kinds
   localparam logic [1:0] FD_NONE  = 2'd0;
   localparam logic [1:0] FD_KEY   = 2'd1;
   localparam logic [1:0] FD_VALUE = 2'd2;

   // characters
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  error_site;
      logic [1:0]  field_done;
      logic [11:0] field_start;
      logic [12:0] field_length;
      logic [7:0]  pair_number;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [12:0] byte_offset;
      logic [12:0] token_begin;
      logic [15:0] visits_used;
      logic [7:0]  pair_count;
   } parse_state_type;

   // letters, digits, underscore and dot
   function automatic logic name_char(input logic [7:0] c);
      name_char = c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                            CH_USCORE, CH_DOT};
   endfunction

endpackage
`default_nettype wire

[rtl/core/lvsp_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lvsp_step
// One parser step: from the current parse state and one input word, the
// result word and the next parse state.
// ----------------------------------------------------------------------------
module lvsp_step
   import lvsp_pkg::*;
(
   input  parse_state_type cur_state,
   input  req_word_type    in_word,
   input  logic [15:0]     visit_budget,
   output parse_state_type nxt_state,
   output rsp_word_type    out_word
);

   logic        finish;
   logic [1:0]  fin_status;
   logic [3:0]  fin_site;
   logic        counted;
   logic [16:0] visits_sum;
   logic [8:0]  pairs_sum;
   logic [7:0]  c;
   logic [12:0] off;

   always_comb begin
      c          = in_word.text_byte;
      off        = cur_state.byte_offset;
      nxt_state  = cur_state;
      out_word   = '0;
      finish     = 1'b0;
      fin_status = ST_RUN;
      fin_site   = SITE_NONE;
      counted    = cur_state.phase inside {PH_START, PH_LABEL, PH_OPENQ,
                                           PH_VALUE, PH_COMMA};
      visits_sum = {1'b0, cur_state.visits_used} + 17'd1;
      pairs_sum  = {1'b0, cur_state.pair_count} + 9'd1;

      if (in_word.end_of_text) begin
         finish     = 1'b1;
         fin_status = ST_INVALID;
      end else if (off >= 13'(MAX_TEXT_LEN)) begin
         finish     = 1'b1;
         fin_status = ST_INVALID;
      end else if (counted && (visits_sum >= {1'b0, visit_budget})) begin
         finish     = 1'b1;
         fin_status = ST_INVALID;
      end else begin
         if (counted) begin
            nxt_state.visits_used = visits_sum[15:0];
         end
         case (cur_state.phase)
            PH_START: begin
               if (c != CH_LBRACE) begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_START;
               end else begin
                  nxt_state.token_begin = off + 13'd1;
                  nxt_state.phase       = PH_LABEL;
               end
            end
            PH_LABEL: begin
               if (c == CH_COLON) begin
                  out_word.field_done   = FD_KEY;
                  out_word.field_start  = cur_state.token_begin[11:0];
                  out_word.field_length = off - cur_state.token_begin;
                  out_word.pair_number  = cur_state.pair_count;
                  nxt_state.phase       = PH_OPENQ;
               end else if (!name_char(c)) begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_LABEL;
               end
            end
            PH_OPENQ: begin
               if (c == CH_QUOTE) begin
                  nxt_state.token_begin = off + 13'd1;
                  nxt_state.phase       = PH_VALUE;
               end else if (c == CH_PCT) begin
                  nxt_state.phase = PH_OQ2;
               end else begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_OQ_OTHER;
               end
            end
            PH_OQ2: begin
               if (c != CH_TWO) begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_OQ_TWO;
               end else begin
                  nxt_state.phase = PH_OQ7;
               end
            end
            PH_OQ7: begin
               if (c != CH_SEVEN) begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_OQ_SEVEN;
               end else begin
                  nxt_state.token_begin = off + 13'd1;
                  nxt_state.phase       = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (c == CH_QUOTE) begin
                  out_word.field_done   = FD_VALUE;
                  out_word.field_start  = cur_state.token_begin[11:0];
                  out_word.field_length = off - cur_state.token_begin;
                  out_word.pair_number  = cur_state.pair_count;
                  nxt_state.phase       = PH_COMMA;
               end else if (c == CH_PCT) begin
                  nxt_state.phase = PH_VQ2;
               end else if (!name_char(c)) begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_VAL_OTHER;
               end
            end
            PH_VQ2: begin
               if (c != CH_TWO) begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_VAL_TWO;
               end else begin
                  nxt_state.phase = PH_VQ7;
               end
            end
            PH_VQ7: begin
               if (c != CH_SEVEN) begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_VAL_SEVEN;
               end else begin
                  // the escape's three bytes are not part of the value
                  out_word.field_done   = FD_VALUE;
                  out_word.field_start  = cur_state.token_begin[11:0];
                  out_word.field_length = off - 13'd2 - cur_state.token_begin;
                  out_word.pair_number  = cur_state.pair_count;
                  nxt_state.phase       = PH_COMMA;
               end
            end
            PH_COMMA: begin
               if (c == CH_COMMA) begin
                  if (pairs_sum >= 9'(MAX_PAIRS)) begin
                     finish = 1'b1; fin_status = ST_INVALID;
                  end else begin
                     nxt_state.pair_count  = pairs_sum[7:0];
                     nxt_state.token_begin = off + 13'd1;
                     nxt_state.phase       = PH_LABEL;
                  end
               end else if (c == CH_RBRACE) begin
                  finish = 1'b1; fin_status = ST_DONE;
               end else begin
                  finish = 1'b1; fin_status = ST_UNEXP; fin_site = SITE_COMMA;
               end
            end
            default: begin
               finish = 1'b1; fin_status = ST_INVALID;
            end
         endcase
      end

      if (finish) begin
         out_word            = '0;
         out_word.status     = fin_status;
         out_word.error_site = fin_site;
         nxt_state           = '0;
         nxt_state.phase     = PH_START;
      end else begin
         nxt_state.byte_offset = off + 13'd1;
      end
   end

endmodule
`default_nettype wire

[rtl/core/label_value_spec_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// label_value_spec_parser
// Streaming parser for text specs of the form {key:'value',key:'value'}.
// ----------------------------------------------------------------------------
// Each accepted req word carries one text byte (or the end-of-text marker)
// and produces exactly one rsp word: a status (running, completed,
// unexpected character with its site, invalid) and, when a key or a value
// has just ended, its start offset, length and pair index. After completed,
// unexpected or invalid the parser restarts and expects '{' again. A word
// is held in the input register, where the combinational step logic turns
// it into a result that is loaded into the output register, which drives
// rsp_valid; a full output register that is not drained stalls the input.
// Throughput is one word per cycle while rsp_ready is high. csr writes
// set the visit budget; write it only while no word is in flight.
// ----------------------------------------------------------------------------
module label_value_spec_parser
   import lvsp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // input byte stream
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire req_word_type req_word,
   // result stream
   output      logic         rsp_valid,
   input  wire logic         rsp_ready,
   output      rsp_word_type rsp_word,
   // visit budget register
   input  wire logic         csr_write_enable,
   input  wire logic [15:0]  csr_write_data
);

   // input register
   logic            in_valid_ff, in_valid_in;
   req_word_type    in_word_ff,  in_word_in;
   // output register
   logic            out_valid_ff, out_valid_in;
   rsp_word_type    out_word_ff,  out_word_in;
   // parse state and budget
   parse_state_type state_ff, state_in;
   logic [15:0]     budget_ff, budget_in;

   parse_state_type step_state;
   rsp_word_type    step_word;
   logic            advance;

   lvsp_step u_step (
      .cur_state    (state_ff),
      .in_word      (in_word_ff),
      .visit_budget (budget_ff),
      .nxt_state    (step_state),
      .out_word     (step_word)
   );

   // the held word moves on when the output register is free or drains now
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      state_in     = state_ff;
      budget_in    = budget_ff;

      if (csr_write_enable) begin
         budget_in = csr_write_data;
      end

      // output register drains on handshake
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      // step the parser and load the result
      if (advance) begin
         out_valid_in = 1'b1;
         out_word_in  = step_word;
         state_in     = step_state;
         in_valid_in  = 1'b0;
      end

      // capture a new byte
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         state_ff          <= {PH_START, 13'd0, 13'd0, 16'd0, 8'd0};
         budget_ff         <= VISIT_BUDGET_RESET;
      end else begin
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         state_ff          <= state_in;
         budget_ff         <= budget_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

endmodule
`default_nettype wire

[tb/tb_label_value_spec_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_label_value_spec_parser
// Self-checking bench for the label/value spec parser. A short table of
// bytes walks every phase and the fixed-outcome cases. The smallest budget
// and random specs under several visit budgets follow, broken at random.
// Results are checked against the typed outcome, else an in-bench parser mirror.
// ----------------------------------------------------------------------------
module tb_label_value_spec_parser;
   import lvsp_pkg::*;

   localparam int STALL_LIMIT        = 2000;
   localparam int RANDOM_PHASE_WORDS = 90;
   localparam int RANDOM_PHASES      = 6;
   localparam int LOG_CAP            = 200;
   localparam int DIRECTED_COUNT     = 25;

   // one directed word; known marks rows whose outcome is typed in here
   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
      logic       known;
      logic [1:0] status;
      logic [3:0] site;
   } stim_row_type;

   // rows without a typed outcome are left to the mirror
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{8'h00,     1'b1, 1'b1, ST_INVALID, SITE_NONE},   // empty text
      '{8'hFF,     1'b1, 1'b1, ST_INVALID, SITE_NONE},   // marker, byte ignored
      '{8'h00,     1'b0, 1'b1, ST_UNEXP,   SITE_START},
      '{8'hFF,     1'b0, 1'b1, ST_UNEXP,   SITE_START},
      '{CH_LBRACE, 1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{8'hFF,     1'b0, 1'b1, ST_UNEXP,   SITE_LABEL},
      '{CH_LBRACE, 1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{"k",       1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{CH_USCORE, 1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{CH_DOT,    1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{"9",       1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{CH_COLON,  1'b0, 1'b0, ST_RUN,     SITE_NONE},   // key ends
      '{CH_PCT,    1'b0, 1'b1, ST_RUN,     SITE_NONE},   // escaped open quote
      '{CH_TWO,    1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{CH_SEVEN,  1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{"Z",       1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{CH_PCT,    1'b0, 1'b1, ST_RUN,     SITE_NONE},   // escaped close quote
      '{CH_TWO,    1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{CH_SEVEN,  1'b0, 1'b0, ST_RUN,     SITE_NONE},   // value ends
      '{CH_COMMA,  1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{CH_COLON,  1'b0, 1'b0, ST_RUN,     SITE_NONE},   // empty key
      '{CH_QUOTE,  1'b0, 1'b1, ST_RUN,     SITE_NONE},
      '{CH_QUOTE,  1'b0, 1'b0, ST_RUN,     SITE_NONE},   // empty value
      '{CH_RBRACE, 1'b0, 1'b1, ST_DONE,    SITE_NONE},
      '{8'hFF,     1'b1, 1'b1, ST_INVALID, SITE_NONE}    // marker after completion
   };

   // dut ports; the ones driven here are known from time zero
   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_ready;
   req_word_type req_word         = '0;
   logic         rsp_valid;
   logic         rsp_ready        = 1'b1;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [15:0]  csr_write_data   = '0;

   // mirror of the parser state and the visit budget
   logic [3:0]   mirror_phase  = PH_START;
   int unsigned  mirror_offset = 0;
   int unsigned  mirror_begin  = 0;
   int unsigned  mirror_visits = 0;
   int unsigned  mirror_pairs  = 0;
   logic [15:0]  mirror_budget = VISIT_BUDGET_RESET;

   // result words still owed by the dut, oldest first
   rsp_word_type pending_results [$];
   // text of the next random spec
   req_word_type spec_words [$];

   // typed outcome of the word now on req_word, when the table gives one
   logic         typed_pending = 1'b0;
   rsp_word_type typed_word    = '0;

   logic         idling_on     = 1'b1;
   int           ready_hold    = 0;
   int           quiet_cycles  = 0;
   int           words_sent    = 0;
   int           results_seen  = 0;
   int           error_count   = 0;

   label_value_spec_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // parser mirror
   // ---------------------------------------------------------------------

   function automatic logic is_label_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == CH_USCORE || c == CH_DOT;
   endfunction

   // a key or value just closed; it starts at mirror_begin
   function automatic rsp_word_type ended_field(input logic [1:0] kind,
                                                input int unsigned len);
      rsp_word_type r;
      r = '0;
      r.field_done   = kind;
      r.field_start  = 12'(mirror_begin);
      r.field_length = 13'(len);
      r.pair_number  = 8'(mirror_pairs);
      return r;
   endfunction

   // advance the mirror by one word and return the result it should give
   function automatic rsp_word_type next_parse_result(input req_word_type w);
      rsp_word_type r;
      logic [7:0]   c;
      logic [3:0]   bad_site;
      int unsigned  off;
      r        = '0;
      c        = w.text_byte;
      bad_site = SITE_NONE;
      off      = mirror_offset;
      if (w.end_of_text || off >= MAX_TEXT_LEN) begin
         r.status = ST_INVALID;
      end else begin
         // the escape bytes after a percent sign are not budgeted
         if (mirror_phase == PH_START || mirror_phase == PH_LABEL ||
             mirror_phase == PH_OPENQ || mirror_phase == PH_VALUE ||
             mirror_phase == PH_COMMA) begin
            mirror_visits++;
            if (mirror_visits >= mirror_budget)
               r.status = ST_INVALID;
         end
         if (r.status == ST_RUN) begin
            case (mirror_phase)
               PH_START: begin
                  if (c != CH_LBRACE) begin
                     bad_site = SITE_START;
                  end else begin
                     mirror_begin = off + 1;
                     mirror_phase = PH_LABEL;
                  end
               end
               PH_LABEL: begin
                  if (c == CH_COLON) begin
                     r = ended_field(FD_KEY, off - mirror_begin);
                     mirror_phase = PH_OPENQ;
                  end else if (!is_label_char(c)) begin
                     bad_site = SITE_LABEL;
                  end
               end
               PH_OPENQ: begin
                  if (c == CH_QUOTE) begin
                     mirror_begin = off + 1;
                     mirror_phase = PH_VALUE;
                  end else if (c == CH_PCT) begin
                     mirror_phase = PH_OQ2;
                  end else begin
                     bad_site = SITE_OQ_OTHER;
                  end
               end
               PH_OQ2: begin
                  if (c != CH_TWO) bad_site = SITE_OQ_TWO;
                  else mirror_phase = PH_OQ7;
               end
               PH_OQ7: begin
                  if (c != CH_SEVEN) begin
                     bad_site = SITE_OQ_SEVEN;
                  end else begin
                     mirror_begin = off + 1;
                     mirror_phase = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  if (c == CH_QUOTE) begin
                     r = ended_field(FD_VALUE, off - mirror_begin);
                     mirror_phase = PH_COMMA;
                  end else if (c == CH_PCT) begin
                     mirror_phase = PH_VQ2;
                  end else if (!is_label_char(c)) begin
                     bad_site = SITE_VAL_OTHER;
                  end
               end
               PH_VQ2: begin
                  if (c != CH_TWO) bad_site = SITE_VAL_TWO;
                  else mirror_phase = PH_VQ7;
               end
               PH_VQ7: begin
                  if (c != CH_SEVEN) begin
                     bad_site = SITE_VAL_SEVEN;
                  end else begin
                     // the escape is not part of the value
                     r = ended_field(FD_VALUE, off - 2 - mirror_begin);
                     mirror_phase = PH_COMMA;
                  end
               end
               PH_COMMA: begin
                  if (c == CH_COMMA) begin
                     if (mirror_pairs + 1 >= MAX_PAIRS) begin
                        r.status = ST_INVALID;
                     end else begin
                        mirror_pairs++;
                        mirror_begin = off + 1;
                        mirror_phase = PH_LABEL;
                     end
                  end else if (c == CH_RBRACE) begin
                     r.status = ST_DONE;
                  end else begin
                     bad_site = SITE_COMMA;
                  end
               end
               default: r.status = ST_INVALID;
            endcase
            if (bad_site != SITE_NONE) begin
               r.status     = ST_UNEXP;
               r.error_site = bad_site;
            end
         end
      end
      // any final status sends the parser back to the opening brace
      if (r.status != ST_RUN) begin
         mirror_phase  = PH_START;
         mirror_offset = 0;
         mirror_begin  = 0;
         mirror_visits = 0;
         mirror_pairs  = 0;
      end else begin
         mirror_offset = off + 1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      // keep the log short when the dut is badly off
      if (error_count < LOG_CAP)
         $display("mismatch at result %0d: %s got %0d expected %0d",
                  results_seen, what, got, want);
      error_count++;
   endtask

   // accepted req words feed the mirror, accepted rsp words are checked
   always @(posedge clock) begin : monitor
      rsp_word_type predicted;
      rsp_word_type wanted;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = next_parse_result(req_word);
            pending_results.push_back(typed_pending ? typed_word : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("word with nothing pending, status", rsp_word.status, 0);
            end else begin
               wanted = pending_results.pop_front();
               if (rsp_word.status !== wanted.status)
                  report_mismatch("status", rsp_word.status, wanted.status);
               if (rsp_word.error_site !== wanted.error_site)
                  report_mismatch("error_site", rsp_word.error_site, wanted.error_site);
               if (rsp_word.field_done !== wanted.field_done)
                  report_mismatch("field_done", rsp_word.field_done, wanted.field_done);
               if (rsp_word.field_start !== wanted.field_start)
                  report_mismatch("field_start", rsp_word.field_start, wanted.field_start);
               if (rsp_word.field_length !== wanted.field_length)
                  report_mismatch("field_length", rsp_word.field_length,
                                  wanted.field_length);
               if (rsp_word.pair_number !== wanted.pair_number)
                  report_mismatch("pair_number", rsp_word.pair_number, wanted.pair_number);
            end
            results_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver back-pressure and watchdog
   // ---------------------------------------------------------------------

   // random stall bursts while idling is allowed
   always @(negedge clock) begin
      if (!idling_on) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 11) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 12);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // cycles in a row where neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_word_type text_word(input logic [7:0] c);
      return {c, 1'b0};
   endfunction

   function automatic logic [7:0] random_name_char();
      int unsigned n;
      n = $urandom_range(0, 63);
      if (n < 26) return 8'h61 + 8'(n);
      if (n < 52) return 8'h41 + 8'(n - 26);
      if (n < 62) return 8'h30 + 8'(n - 52);
      return (n == 62) ? CH_USCORE : CH_DOT;
   endfunction

   // a quote, plain or written as the percent escape
   function automatic void add_quote(input logic escaped);
      if (escaped) begin
         spec_words.push_back(text_word(CH_PCT));
         spec_words.push_back(text_word(CH_TWO));
         spec_words.push_back(text_word(CH_SEVEN));
      end else begin
         spec_words.push_back(text_word(CH_QUOTE));
      end
   endfunction

   // a well-formed spec with random content, then altered in six draws out of ten
   function automatic void compose_spec();
      int          pairs;
      int unsigned pos;
      logic [7:0]  pick;
      spec_words.delete();
      spec_words.push_back(text_word(CH_LBRACE));
      pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
      for (int p = 0; p < pairs; p++) begin
         repeat ($urandom_range(0, 3)) spec_words.push_back(text_word(random_name_char()));
         spec_words.push_back(text_word(CH_COLON));
         add_quote(1'($urandom_range(0, 1)));
         repeat ($urandom_range(0, 3)) spec_words.push_back(text_word(random_name_char()));
         add_quote(1'($urandom_range(0, 1)));
         spec_words.push_back(text_word((p == pairs - 1) ? CH_RBRACE : CH_COMMA));
      end
      pos = $urandom_range(0, spec_words.size() - 1);
      case ($urandom_range(0, 9))
         0, 1, 2: spec_words[pos] = text_word(8'($urandom_range(0, 255)));
         3: begin
            // a structural character in the wrong place
            case ($urandom_range(0, 7))
               0: pick = CH_LBRACE;
               1: pick = CH_RBRACE;
               2: pick = CH_COLON;
               3: pick = CH_COMMA;
               4: pick = CH_QUOTE;
               5: pick = CH_PCT;
               6: pick = CH_TWO;
               default: pick = CH_SEVEN;
            endcase
            spec_words[pos] = text_word(pick);
         end
         4: begin
            // text cut short
            while (spec_words.size() > pos) void'(spec_words.pop_back());
            spec_words.push_back({8'($urandom_range(0, 255)), 1'b1});
         end
         5: spec_words.insert(pos, text_word(8'($urandom_range(0, 255))));
         default: ;
      endcase
   endfunction

   // present one word at a falling edge and hold it until it is taken
   task automatic send_word(input req_word_type w, input logic has_typed,
                            input rsp_word_type typed);
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_word      <= w;
      typed_pending = has_typed;
      typed_word    = typed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] c);
      send_word(text_word(c), 1'b0, '0);
   endtask

   // either a random spec or a few noise bytes, always from the opening brace
   task automatic send_random_text();
      if (mirror_phase != PH_START)
         send_word({8'($urandom_range(0, 255)), 1'b1}, 1'b0, '0);
      if ($urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
         compose_spec();
         foreach (spec_words[k]) send_word(spec_words[k], 1'b0, '0);
      end
   endtask

   // let every owed word drain, then write the budget
   task automatic program_budget(input logic [15:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mirror_budget    = value;
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin : main
      rsp_word_type known_word;
      logic [15:0]  budget_pick;
      int           phase_start;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk through every phase at the reset budget
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         known_word            = '0;
         known_word.status     = DIRECTED_ROWS[i].status;
         known_word.error_site = DIRECTED_ROWS[i].site;
         send_word({DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].eot},
                   DIRECTED_ROWS[i].known, known_word);
      end

      // smallest budget: every counted visit is already over
      program_budget(16'd1);
      send_byte(CH_LBRACE);
      repeat (5) send_byte(8'($urandom_range(0, 255)));

      // random specs under a spread of budgets; some stretches without idling,
      // none at all in the last one
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: budget_pick = VISIT_BUDGET_RESET;
            1: budget_pick = 16'($urandom_range(2, 40));
            2: budget_pick = 16'hFFFF;
            3: budget_pick = 16'($urandom_range(3, 15));
            4: budget_pick = 16'($urandom_range(20, 300));
            default: budget_pick = 16'($urandom_range(1000, 65535));
         endcase
         program_budget(budget_pick);
         idling_on   = (ph != 2 && ph != RANDOM_PHASES - 1);
         phase_start = words_sent;
         while (words_sent - phase_start < RANDOM_PHASE_WORDS) send_random_text();
      end

      // drain, then give the pipeline time to show any stray word
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/core/lvsp_pkg.sv
rtl/core/lvsp_step.sv
rtl/core/label_value_spec_parser.sv
tb/tb_label_value_spec_parser.sv
